/* hdl/kbdkc_pkg.sv */
// Package for the keyboard report key change detector.
// Holds key and control types, slot counts and event codes.
// No dependencies.
package kbdkc_pkg;

	// slot counts: SLOT_CAP slots arrive per report, NUM_KEYS of them are tracked
	localparam int SLOT_CAP = 6;
	localparam int NUM_KEYS = 6;
	localparam int CNT_W    = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;

	typedef logic [7:0]       key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam cnt_t CNT_LAST = cnt_t'(NUM_KEYS - 1);

	// event codes
	localparam logic EV_PRESS   = 1'b0;
	localparam logic EV_RELEASE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_PRESS,
		ST_RELEASE,
		ST_FLUSH
	} state_t;

	// control broadcast from the sequencer to every cell
	typedef struct packed {
		logic load;
		logic press_step;
		logic rel_step;
		key_t probe_key;
	} cell_ctl_t;

	// what the sequencer sees from the head and tail of the chain
	typedef struct packed {
		key_t head_cur;
		key_t head_scr;
		logic taken;
	} chain_sts_t;

endpackage

/* hdl/kbdkc_rpt_if.sv */
// Report channel: six key slots with a valid/ready handshake.
// Depends on kbdkc_pkg.
interface kbdkc_rpt_if import kbdkc_pkg::*; ();
	logic valid;
	logic ready;
	key_t key_slot_0;
	key_t key_slot_1;
	key_t key_slot_2;
	key_t key_slot_3;
	key_t key_slot_4;
	key_t key_slot_5;

	modport source (
		output valid, key_slot_0, key_slot_1, key_slot_2,
		output key_slot_3, key_slot_4, key_slot_5,
		input  ready
	);
	modport sink (
		input  valid, key_slot_0, key_slot_1, key_slot_2,
		input  key_slot_3, key_slot_4, key_slot_5,
		output ready
	);
endinterface

/* hdl/kbdkc_evt_if.sv */
// Event channel: one press or release event per transaction.
// Depends on kbdkc_pkg.
interface kbdkc_evt_if import kbdkc_pkg::*; ();
	logic valid;
	logic ready;
	logic event_kind;
	key_t key_value;
	logic last_event;

	modport source (output valid, event_kind, key_value, last_event, input ready);
	modport sink   (input valid, event_kind, key_value, last_event, output ready);
endinterface

/* hdl/kbdkc_cell.sv */
// One cell of the slot chain: holds a stored slot and its scratch copy.
// Depends on kbdkc_pkg.
module kbdkc_cell import kbdkc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cell_ctl_t ctl,
	input  key_t      load_key,
	input  key_t      cur_next,
	input  key_t      scr_next,
	input  logic      taken_in,
	output logic      taken_out,
	output key_t      cur,
	output key_t      scr
);

	key_t cur_q;
	key_t scr_q;
	logic match;

	// first-match chain: only the earliest matching cell takes the probe key
	assign match     = (ctl.probe_key != '0) && (scr_q == ctl.probe_key);
	assign taken_out = taken_in | match;
	assign cur       = cur_q;
	assign scr       = scr_q;

	// slot registers: load, rotate current slots, or shift scratch towards head
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q <= '0;
			scr_q <= '0;
		end else if (ctl.load) begin
			cur_q <= load_key;
			scr_q <= cur_q;
		end else if (ctl.press_step) begin
			cur_q <= cur_next;
			if (match && !taken_in) begin
				scr_q <= '0;
			end
		end else if (ctl.rel_step) begin
			scr_q <= scr_next;
		end
	end

endmodule

/* hdl/kbdkc_ctrl.sv */
// Sequencer: steps the cell chain, holds one pending event, drives the output register.
// Depends on kbdkc_pkg and kbdkc_evt_if.
module kbdkc_ctrl import kbdkc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  chain_sts_t           sts,
	output cell_ctl_t            ctl,
	kbdkc_evt_if.source          evt
);

	state_t state_q;
	state_t state_nxt;
	cnt_t   cnt_q;

	logic   pend_v_q;
	logic   pend_kind_q;
	key_t   pend_key_q;

	logic   out_v_q;
	logic   out_kind_q;
	key_t   out_key_q;
	logic   out_last_q;

	logic   accept;
	logic   ev_v;
	logic   ev_kind;
	key_t   ev_key;
	logic   out_free;
	logic   advance;
	logic   stepping;
	logic   push_out;
	logic   flush_go;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_v_q || evt.ready;

	// event produced by the current step
	always_comb begin
		ev_v    = 1'b0;
		ev_kind = EV_PRESS;
		ev_key  = sts.head_cur;
		case (state_q)
			ST_PRESS: begin
				ev_v    = (sts.head_cur != '0) && !sts.taken;
				ev_kind = EV_PRESS;
				ev_key  = sts.head_cur;
			end
			ST_RELEASE: begin
				ev_v    = (sts.head_scr != '0);
				ev_kind = EV_RELEASE;
				ev_key  = sts.head_scr;
			end
			default: begin
				ev_v = 1'b0;
			end
		endcase
	end

	// a step stalls only when it would displace the pending event into a full output
	assign advance  = !(ev_v && pend_v_q) || out_free;
	assign flush_go = !pend_v_q || out_free;

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_nxt = ST_PRESS;
			end
			ST_PRESS: begin
				if (advance && (cnt_q == CNT_LAST)) state_nxt = ST_RELEASE;
			end
			ST_RELEASE: begin
				if (advance && (cnt_q == CNT_LAST)) state_nxt = ST_FLUSH;
			end
			ST_FLUSH: begin
				if (flush_go) state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		in_ready       = (state_q == ST_IDLE);
		stepping       = 1'b0;
		ctl.load       = in_valid && (state_q == ST_IDLE);
		ctl.press_step = 1'b0;
		ctl.rel_step   = 1'b0;
		ctl.probe_key  = sts.head_cur;
		push_out       = 1'b0;
		case (state_q)
			ST_PRESS: begin
				stepping       = advance;
				ctl.press_step = advance;
				push_out       = advance && ev_v && pend_v_q;
			end
			ST_RELEASE: begin
				stepping     = advance;
				ctl.rel_step = advance;
				push_out     = advance && ev_v && pend_v_q;
			end
			ST_FLUSH: begin
				push_out = pend_v_q && out_free;
			end
			default: begin
				stepping = 1'b0;
			end
		endcase
	end

	// state and step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_nxt;
			if (accept || (stepping && (cnt_q == CNT_LAST))) begin
				cnt_q <= '0;
			end else if (stepping) begin
				cnt_q <= cnt_q + cnt_t'(1);
			end
		end
	end

	// pending event: last flag is only known once the next event or the end appears
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
		end else if (stepping && ev_v) begin
			pend_v_q <= 1'b1;
		end else if ((state_q == ST_FLUSH) && push_out) begin
			pend_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (stepping && ev_v) begin
			pend_kind_q <= ev_kind;
			pend_key_q  <= ev_key;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push_out) begin
			out_v_q <= 1'b1;
		end else if (evt.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push_out) begin
			out_kind_q <= pend_kind_q;
			out_key_q  <= pend_key_q;
			out_last_q <= (state_q == ST_FLUSH);
		end
	end

	assign evt.valid      = out_v_q;
	assign evt.event_kind = out_kind_q;
	assign evt.key_value  = out_key_q;
	assign evt.last_event = out_last_q;

	// no event may be left pending once the sequencer is idle
	a_idle_no_pend: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> !pend_v_q)
		else $error("pending event left in idle");

	// an accepted report always starts the press pass with a cleared counter
	a_accept_start: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> ((state_q == ST_PRESS) && (cnt_q == '0)))
		else $error("report accepted without starting press pass");

	// the step counter never runs past the last slot
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_LAST)
		else $error("step counter out of range");

	// the output register is only loaded while it is free
	a_push_free: assert property (@(posedge clk) disable iff (!arst_n)
		push_out |-> out_free)
		else $error("output register overwritten");

endmodule

/* hdl/keyboard_report_key_change_detector_unit.sv */
// Keyboard report key change detector: a chain of NUM_KEYS slot cells and a sequencer.
// Per report: an accept, NUM_KEYS press steps, NUM_KEYS release steps and a flush;
// a new report is accepted only once the sequencer is back in idle. The step loop
// over the chain sets the rate, and a stalled event output holds the steps.
// Asynchronous reset clears stored slots to zero and empties the event output.
module keyboard_report_key_change_detector_unit import kbdkc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	kbdkc_rpt_if.sink   rpt,
	kbdkc_evt_if.source evt
);

	key_t       slot_in [SLOT_CAP];
	key_t       cur     [NUM_KEYS];
	key_t       scr     [NUM_KEYS];
	logic       taken   [NUM_KEYS+1];
	cell_ctl_t  ctl;
	chain_sts_t sts;

	assign slot_in[0] = rpt.key_slot_0;
	assign slot_in[1] = rpt.key_slot_1;
	assign slot_in[2] = rpt.key_slot_2;
	assign slot_in[3] = rpt.key_slot_3;
	assign slot_in[4] = rpt.key_slot_4;
	assign slot_in[5] = rpt.key_slot_5;

	assign taken[0] = 1'b0;

	// cell chain: current slots rotate towards the head, scratch shifts in zeros
	for (genvar i = 0; i < NUM_KEYS; i++) begin : g_cell
		key_t cur_nb;
		key_t scr_nb;
		if (i == NUM_KEYS - 1) begin : g_tail
			assign cur_nb = cur[0];
			assign scr_nb = '0;
		end else begin : g_mid
			assign cur_nb = cur[i+1];
			assign scr_nb = scr[i+1];
		end
		kbdkc_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.load_key  (slot_in[i]),
			.cur_next  (cur_nb),
			.scr_next  (scr_nb),
			.taken_in  (taken[i]),
			.taken_out (taken[i+1]),
			.cur       (cur[i]),
			.scr       (scr[i])
		);
	end

	assign sts.head_cur = cur[0];
	assign sts.head_scr = scr[0];
	assign sts.taken    = taken[NUM_KEYS];

	kbdkc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (rpt.valid),
		.in_ready (rpt.ready),
		.sts      (sts),
		.ctl      (ctl),
		.evt      (evt)
	);

endmodule
